>>> hdl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// No dependencies; used by mme_mac and matrix_multiply_engine.
package mme_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT,
        ST_ERR
    } t_state;

    // Tags one operand pair through the multiply-accumulate pipe.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

>>> hdl/mme_mac.sv
// Multiply-accumulate datapath: registered 16x16 product, then accumulator.
// Depends on mme_pkg.
module mme_mac import mme_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_sum
);

    localparam int ACC_W = PROD_W + $clog2(MAX_DIM) + 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(2147483647)) - ACC_W'(1);

    t_mac_ctl                  r_prod_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    logic signed [ACC_W-1:0]   n_acc;

    always_comb begin
        if (r_prod_ctl.first) begin
            n_acc = ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ctl <= '0;
            r_done     <= 1'b0;
        end else begin
            r_prod_ctl <= i_ctl;
            r_done     <= r_prod_ctl.valid && r_prod_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
        if (r_prod_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;

    always_comb begin
        if (r_acc > SAT_MAX) begin
            o_sum = PROD_W'(SAT_MAX);
        end else if (r_acc < SAT_MIN) begin
            o_sum = PROD_W'(SAT_MIN);
        end else begin
            o_sum = PROD_W'(r_acc);
        end
    end

endmodule

>>> hdl/matrix_multiply_engine.sv
// Matrix multiply engine top level: element stores, sequencer, output register.
// Depends on mme_pkg and mme_mac.
//
// A load transfer (tuser 0 for A, 1 for B) writes one Q8.8 element. A compute
// transfer (tuser 2) holds the input until the whole product is out: each
// output element is built one product at a time, set by the one read port of
// each store feeding a single multiplier, and may be held by a stall on the
// output. A dimension mismatch gives one result with tuser set.
// The stores come up undefined; load every element a compute will read.
module matrix_multiply_engine import mme_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // elem_row[2:0], elem_col[5:3], elem_value[21:6]
    input  logic [1:0]  i_s_tuser,   // cmd[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6]
    output logic        o_m_tlast,
    output logic        o_m_tuser    // dim_error
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [3:0] MAX_DIM_4 = 4'(MAX_DIM);

    function automatic logic [IDX_W-1:0] dim_last(input logic [3:0] v);
        logic [3:0] e;
        begin
            if (v == 4'd0) begin
                e = 4'd1;
            end else if (v > MAX_DIM_4) begin
                e = MAX_DIM_4;
            end else begin
                e = v;
            end
            return IDX_W'(e - 4'd1);
        end
    endfunction

    // config registers
    logic [3:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    // input fields
    logic [1:0]              in_cmd;
    logic [2:0]              in_row, in_col;
    logic signed [ELEM_W-1:0] in_value;
    logic                    in_xfer, in_in_range;

    // sequencer
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_rlast, r_clast, r_klast;
    logic [IDX_W-1:0]  r_row, r_col, r_k;
    logic              issue, emit, emit_err, elem_last, out_free;

    // stores
    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];
    logic signed [ELEM_W-1:0] r_rd_a, r_rd_b;
    logic [ADDR_W-1:0]        wr_addr, rd_addr_a, rd_addr_b;
    t_mac_ctl                 r_rd_ctl, issue_ctl;

    // MAC
    logic                     mac_done;
    logic signed [PROD_W-1:0] mac_sum;

    // output register
    logic              r_out_valid, r_out_last, r_out_err;
    logic [2:0]        r_out_row, r_out_col;
    logic [PROD_W-1:0] r_out_value;

    assign in_cmd      = i_s_tuser;
    assign in_row      = i_s_tdata[2:0];
    assign in_col      = i_s_tdata[5:3];
    assign in_value    = i_s_tdata[21:6];
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign in_in_range = ({1'b0, in_row} < MAX_DIM_4) && ({1'b0, in_col} < MAX_DIM_4);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= 4'd8;
            r_a_cols <= 4'd8;
            r_b_rows <= 4'd8;
            r_b_cols <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_A_ROWS: r_a_rows <= i_cfg_data;
                REG_A_COLS: r_a_cols <= i_cfg_data;
                REG_B_ROWS: r_b_rows <= i_cfg_data;
                REG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free  = !r_out_valid || i_m_tready;
    assign elem_last = (r_row == r_rlast) && (r_col == r_clast);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && in_cmd == CMD_COMPUTE) begin
                    if (dim_last(r_a_cols) != dim_last(r_b_rows)) begin
                        n_state = ST_ERR;
                    end else begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                if (r_k == r_klast) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = elem_last ? ST_IDLE : ST_ISSUE;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        issue      = 1'b0;
        emit       = 1'b0;
        emit_err   = 1'b0;
        case (r_state)
            ST_IDLE:  o_s_tready = 1'b1;
            ST_ISSUE: issue      = 1'b1;
            ST_WAIT:  ;
            ST_EMIT:  emit       = out_free;
            ST_ERR:   emit_err   = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // loop counters: k steps per cycle of issue, col/row step per emitted element
    always_ff @(posedge i_clk) begin
        if (in_xfer && in_cmd == CMD_COMPUTE) begin
            r_rlast <= dim_last(r_a_rows);
            r_clast <= dim_last(r_b_cols);
            r_klast <= dim_last(r_a_cols);
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            if (issue) begin
                r_k <= (r_k == r_klast) ? '0 : r_k + 1'b1;
            end
            if (emit) begin
                if (r_col == r_clast) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // stores: one write port for loads, one read port each for compute
    assign wr_addr   = {in_row[IDX_W-1:0], in_col[IDX_W-1:0]};
    assign rd_addr_a = {r_row, r_k};
    assign rd_addr_b = {r_k, r_col};

    always_ff @(posedge i_clk) begin
        if (in_xfer && in_in_range && in_cmd == CMD_LOAD_A) begin
            mem_a[wr_addr] <= in_value;
        end
        r_rd_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && in_in_range && in_cmd == CMD_LOAD_B) begin
            mem_b[wr_addr] <= in_value;
        end
        r_rd_b <= mem_b[rd_addr_b];
    end

    assign issue_ctl.valid = issue;
    assign issue_ctl.first = (r_k == '0);
    assign issue_ctl.last  = (r_k == r_klast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl <= issue_ctl;
        end
    end

    mme_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .o_done  (mac_done),
        .o_sum   (mac_sum)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit || emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row   <= 3'(r_row);
            r_out_col   <= 3'(r_col);
            r_out_value <= mac_sum;
            r_out_last  <= elem_last;
            r_out_err   <= 1'b0;
        end else if (emit_err) begin
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_out_last  <= 1'b1;
            r_out_err   <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_value, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

endmodule
